// File: rtl/crc16_frame_encoder_core_macros.svh
// assertion macros used by the frame encoder sequencer
`ifndef CRC16_FRAME_ENCODER_CORE_MACROS_SVH
`define CRC16_FRAME_ENCODER_CORE_MACROS_SVH

// checked only out of reset
`define CFE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// checked at every edge, reset included
`define CFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/crc16_fe_pkg.sv
// shared types, constants and crc function of the frame encoder
`timescale 1ns / 1ps
`default_nettype none

package crc16_fe_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_RESET = 16'hFFFF;
    localparam logic [7:0]  SYNC_RESET = 8'hA5;

    // register word indexes on the config port
    localparam logic REG_SYNC_BYTE = 1'b0;
    localparam logic REG_CRC_SEED  = 1'b1;

    // byte position within the bytes one transaction causes
    typedef enum logic [2:0] {
        PH_SYNC,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    typedef struct packed {
        logic       fold;
        logic       load_seed;
        logic [7:0] fold_byte;
    } crc_ctrl_t;

    // one byte through the ccitt polynomial, msb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc16_fe_crc.sv
// running crc register, folds one emitted header or payload byte per cycle while bytes advance
`timescale 1ns / 1ps
`default_nettype none

module crc16_fe_crc
    import crc16_fe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire crc_ctrl_t   crc_ctrl,
    input  wire logic [15:0] crc_seed,
    output logic      [15:0] crc_value
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;

    // sync byte starts a fresh crc from the seed
    assign crc_base = crc_ctrl.load_seed ? crc_seed : crc_reg;

    always_comb begin
        crc_next = crc_reg;
        if (crc_ctrl.fold) begin
            crc_next = crc_fold(crc_base, crc_ctrl.fold_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_RESET;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc_value = crc_reg;

endmodule

`default_nettype wire

// File: rtl/crc16_fe_seq.sv
// item holding register, byte sequencer and output register
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_frame_encoder_core_macros.svh"

module crc16_fe_seq
    import crc16_fe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_type,
    input  wire logic [7:0]  s_payload_len,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_out_byte,
    output logic             m_run_last,
    output logic             m_frame_end,
    input  wire logic [7:0]  sync_byte,
    input  wire logic [15:0] crc_value,
    output crc_ctrl_t        crc_ctrl
);

    logic       hold_valid_reg, hold_valid_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] msg_type_reg;
    logic [7:0] payload_len_reg;
    logic [7:0] data_byte_reg;
    logic       last_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       frame_end_reg;

    logic       adv;
    logic       final_ph;
    logic       accept;
    logic [7:0] byte_sel;
    phase_t     phase_succ;

    assign adv      = hold_valid_reg & (~out_valid_reg | m_ready);
    assign final_ph = (phase_reg == PH_CRC_LO) | ((phase_reg == PH_DATA) & ~last_reg);
    assign s_ready  = ~hold_valid_reg | (adv & final_ph);
    assign accept   = s_valid & s_ready;

    always_comb begin
        byte_sel   = data_byte_reg;
        phase_succ = PH_DATA;
        case (phase_reg)
            PH_SYNC: begin
                byte_sel   = sync_byte;
                phase_succ = PH_TYPE;
            end
            PH_TYPE: begin
                byte_sel   = msg_type_reg;
                phase_succ = PH_LEN;
            end
            PH_LEN: begin
                byte_sel   = payload_len_reg;
                phase_succ = PH_DATA;
            end
            PH_DATA: begin
                byte_sel   = data_byte_reg;
                phase_succ = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                byte_sel   = crc_value[15:8];
                phase_succ = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                byte_sel   = crc_value[7:0];
                phase_succ = PH_DATA;
            end
            default: begin
                byte_sel   = data_byte_reg;
                phase_succ = PH_DATA;
            end
        endcase
    end

    // next state of the holding register and output register
    always_comb begin
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        if (adv) begin
            if (final_ph) begin
                hold_valid_next = 1'b0;
            end else begin
                phase_next = phase_succ;
            end
        end
        if (accept) begin
            hold_valid_next = 1'b1;
            phase_next      = s_first_byte ? PH_SYNC : PH_DATA;
        end
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_DATA;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            msg_type_reg    <= s_msg_type;
            payload_len_reg <= s_payload_len;
            data_byte_reg   <= s_data_byte;
            last_reg        <= s_last_byte;
        end
        if (adv) begin
            out_byte_reg  <= byte_sel;
            run_last_reg  <= final_ph;
            frame_end_reg <= (phase_reg == PH_CRC_LO);
        end
    end

    // header and payload bytes go into the crc, crc bytes do not
    assign crc_ctrl.fold      = adv & ((phase_reg == PH_SYNC) | (phase_reg == PH_TYPE)
                                       | (phase_reg == PH_LEN) | (phase_reg == PH_DATA));
    assign crc_ctrl.load_seed = (phase_reg == PH_SYNC);
    assign crc_ctrl.fold_byte = byte_sel;

    assign m_valid     = out_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_run_last  = run_last_reg;
    assign m_frame_end = frame_end_reg;

    `CFE_ASSERT(a_ready_only_on_drain, aclk, aresetn,
        (hold_valid_reg && s_ready) |-> (adv && final_ph), "ready while item still pending")
    `CFE_ASSERT(a_stall_holds_seq, aclk, aresetn,
        (hold_valid_reg && out_valid_reg && !m_ready) |=> (hold_valid_reg && $stable(phase_reg)),
        "sequencer moved under output stall")
    `CFE_ASSERT_ALWAYS(a_fold_needs_adv, aclk,
        crc_ctrl.fold |-> adv, "crc folded without a byte leaving")
    `CFE_ASSERT(a_end_after_crc_hi, aclk, aresetn,
        (adv && phase_reg == PH_CRC_LO) |-> $past(phase_reg == PH_CRC_HI || phase_reg == PH_CRC_LO),
        "crc low byte without crc high byte")

endmodule

`default_nettype wire

// File: rtl/crc16_frame_encoder_core.sv
// top level of the crc16 frame encoder: config registers and datapath
// a transaction accepted into the holding register sends its bytes out through the output register
// throughput: one output byte per cycle while the receiver takes them; a plain payload byte gives one
// output byte, a first byte four and a last byte three, all through the single output register
// input is taken again in the cycle the last byte of the held item leaves
// synchronous active-low reset clears handshake state, sync byte to 0xA5, crc and seed to 0xFFFF
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_encoder_core
    import crc16_fe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // payload input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_msg_type,
    input  wire logic [7:0]  s_payload_len,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,
    // frame byte output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_out_byte,
    output logic             m_run_last,
    output logic             m_frame_end
);

    logic [7:0]  sync_byte_reg;
    logic [15:0] crc_seed_reg;
    logic        cfg_write;
    logic        reg_index;
    logic [15:0] crc_value;
    crc_ctrl_t   crc_ctrl;

    // word index from the address, byte offset ignored
    assign reg_index = paddr[2];
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= SYNC_RESET;
            crc_seed_reg  <= CRC_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SYNC_BYTE: sync_byte_reg <= pwdata[7:0];
                REG_CRC_SEED:  crc_seed_reg  <= pwdata[15:0];
                default: begin
                    sync_byte_reg <= sync_byte_reg;
                end
            endcase
        end
    end

    // readback of the selected register
    always_comb begin
        case (reg_index)
            REG_SYNC_BYTE: prdata = {24'h000000, sync_byte_reg};
            REG_CRC_SEED:  prdata = {16'h0000, crc_seed_reg};
            default:       prdata = 32'h0000_0000;
        endcase
    end

    // holding register, byte sequencer and output register
    crc16_fe_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_msg_type    (s_msg_type),
        .s_payload_len (s_payload_len),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_frame_end   (m_frame_end),
        .sync_byte     (sync_byte_reg),
        .crc_value     (crc_value),
        .crc_ctrl      (crc_ctrl)
    );

    // running crc, one byte fold per emitted header or payload byte
    crc16_fe_crc u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .crc_ctrl  (crc_ctrl),
        .crc_seed  (crc_seed_reg),
        .crc_value (crc_value)
    );

endmodule

`default_nettype wire

// File: dv/crc16_frame_encoder_core_tb.sv
// testbench for the crc16 frame encoder: directed and random frames, checked byte by byte
`timescale 1ns / 1ps

module crc16_frame_encoder_core_tb;
    import crc16_fe_pkg::*;

    // one byte on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } frame_byte_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_msg_type    = '0;
    logic [7:0]  s_payload_len = '0;
    logic [7:0]  s_data_byte   = '0;
    logic        s_first_byte  = 1'b0;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_frame_end;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: the test bumps hold_seq, the receiver counts it out
    int hold_seq  = 0;
    int hold_len  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // shadow registers and running crc of the predicted frame
    logic [7:0]  sync_shadow = SYNC_RESET;
    logic [15:0] seed_shadow = CRC_RESET;
    logic [15:0] frame_crc   = CRC_RESET;

    frame_byte_t expected_bytes[$];

    int error_count    = 0;
    int items_accepted = 0;
    int bytes_checked  = 0;
    int frames_closed  = 0;
    int reg_writes     = 0;

    crc16_frame_encoder_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_msg_type    (s_msg_type),
        .s_payload_len (s_payload_len),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_frame_end   (m_frame_end)
    );

    always #4 aclk = ~aclk;

    // ccitt update one bit at a time: feedback is crc msb xor data bit
    function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    function automatic void queue_frame_byte(input logic [7:0] b, input logic fold,
                                             input logic ends);
        frame_byte_t fb;
        fb.out_byte  = b;
        fb.run_last  = 1'b0;
        fb.frame_end = ends;
        expected_bytes.push_back(fb);
        if (fold) begin
            frame_crc = ccitt_update(frame_crc, b);
        end
    endfunction

    // bytes one accepted transaction causes: header on first, crc on last
    function automatic void predict_frame_bytes(input logic [7:0] msg, input logic [7:0] len,
                                                input logic [7:0] data, input logic first_flag,
                                                input logic last_flag);
        logic [15:0] crc_out;
        if (first_flag) begin
            frame_crc = seed_shadow;
            queue_frame_byte(sync_shadow, 1'b1, 1'b0);
            queue_frame_byte(msg, 1'b1, 1'b0);
            queue_frame_byte(len, 1'b1, 1'b0);
        end
        queue_frame_byte(data, 1'b1, 1'b0);
        if (last_flag) begin
            // crc bytes are not folded; the running crc keeps its final value
            crc_out = frame_crc;
            queue_frame_byte(crc_out[15:8], 1'b0, 1'b0);
            queue_frame_byte(crc_out[7:0], 1'b0, 1'b1);
        end
        expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
    endfunction

    // receiver: random stalls, or a counted hold-off when the test asks for one
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: register shadows, read-back check, prediction and output compare
    always @(posedge aclk) begin
        frame_byte_t want;
        if (aresetn) begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    reg_writes++;
                    case (paddr[2])
                        REG_SYNC_BYTE: sync_shadow = pwdata[7:0];
                        REG_CRC_SEED:  seed_shadow = pwdata[15:0];
                    endcase
                end else begin
                    case (paddr[2])
                        REG_SYNC_BYTE: begin
                            if (prdata[7:0] !== sync_shadow) begin
                                error_count++;
                                $display("%0t sync_byte read: expected %02h, actual %02h",
                                         $time, sync_shadow, prdata[7:0]);
                            end
                        end
                        REG_CRC_SEED: begin
                            if (prdata[15:0] !== seed_shadow) begin
                                error_count++;
                                $display("%0t crc_seed read: expected %04h, actual %04h",
                                         $time, seed_shadow, prdata[15:0]);
                            end
                        end
                    endcase
                end
            end
            if (s_valid && s_ready) begin
                items_accepted++;
                predict_frame_bytes(s_msg_type, s_payload_len, s_data_byte,
                                    s_first_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected byte: expected none, actual %02h run_last %0b frame_end %0b",
                             $time, m_out_byte, m_run_last, m_frame_end);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.frame_end) begin
                        frames_closed++;
                    end
                    if (m_out_byte !== want.out_byte || m_run_last !== want.run_last ||
                        m_frame_end !== want.frame_end) begin
                        error_count++;
                        $display("%0t byte mismatch: expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                                 $time, want.out_byte, want.run_last, want.frame_end,
                                 m_out_byte, m_run_last, m_frame_end);
                    end
                end
            end
        end
    end

    // valid stays high between back-to-back transactions, dropped only when idling
    task automatic send_payload(input logic [7:0] msg, input logic [7:0] len,
                                input logic [7:0] data, input logic first_flag,
                                input logic last_flag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_msg_type    <= msg;
        s_payload_len <= len;
        s_data_byte   <= data;
        s_first_byte  <= first_flag;
        s_last_byte   <= last_flag;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every predicted byte has come out
    task automatic drain_frame_bytes();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        // the block may still be settling its output register
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write_flag, input logic reg_idx,
                              input logic [31:0] value);
        drain_frame_bytes();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_flag;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // writes carry values wider than the register fields; upper bits must be dropped
    task automatic set_registers(input logic [7:0] sync_value, input logic [15:0] seed_value);
        apb_access(1'b1, REG_SYNC_BYTE, {24'($urandom_range(16777215)), sync_value});
        apb_access(1'b1, REG_CRC_SEED, {16'($urandom), seed_value});
        apb_access(1'b0, REG_SYNC_BYTE, '0);
        apb_access(1'b0, REG_CRC_SEED, '0);
    endtask

    // mostly well-formed frames; now and then a flag is flipped to break the frame
    task automatic send_random_frame();
        int n;
        logic [7:0] msg;
        logic first_flag;
        logic last_flag;
        n   = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(5, 1);
        msg = 8'($urandom);
        for (int i = 0; i < n; i++) begin
            first_flag = (i == 0);
            last_flag  = (i == n - 1);
            if ($urandom_range(19) == 0) begin
                first_flag = ~first_flag;
            end
            if ($urandom_range(19) == 0) begin
                last_flag = ~last_flag;
            end
            send_payload(first_flag ? msg : 8'($urandom),
                         ($urandom_range(1) == 0) ? 8'(n) : 8'($urandom),
                         8'($urandom), first_flag, last_flag);
        end
    endtask

    task automatic test_reset_values();
        apb_access(1'b0, REG_SYNC_BYTE, '0);
        apb_access(1'b0, REG_CRC_SEED, '0);
    endtask

    // bytes with no frame started fold into the crc as it stands after reset
    task automatic test_stray_bytes();
        send_payload(8'h5A, 8'hA5, 8'h00, 1'b0, 1'b0);
        send_payload(8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b1);
    endtask

    // first and last on the same transaction: header, byte and both crc bytes
    task automatic test_single_byte_frames();
        send_payload(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
        send_payload(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_multi_byte_frame();
        send_payload(8'h01, 8'h04, 8'h80, 1'b1, 1'b0);
        send_payload(8'hFF, 8'hFF, 8'h7F, 1'b0, 1'b0);
        send_payload(8'h00, 8'h00, 8'h55, 1'b0, 1'b0);
        send_payload(8'h3C, 8'hC3, 8'hAA, 1'b0, 1'b1);
    endtask

    // after frame end, bytes without a first flag fold on from the final crc until the next first byte
    task automatic test_after_frame_end();
        send_payload(8'h12, 8'h34, 8'h56, 1'b0, 1'b0);
        send_payload(8'h78, 8'h9A, 8'hBC, 1'b0, 1'b1);
    endtask

    // a seed written mid-frame leaves the running crc alone
    task automatic test_seed_mid_frame();
        send_payload(8'h42, 8'h03, 8'h11, 1'b1, 1'b0);
        apb_access(1'b1, REG_CRC_SEED, 32'h0000_1234);
        apb_access(1'b1, REG_SYNC_BYTE, 32'h0000_007E);
        send_payload(8'h00, 8'h00, 8'h22, 1'b0, 1'b0);
        send_payload(8'h00, 8'h00, 8'h33, 1'b0, 1'b1);
        send_payload(8'h43, 8'h01, 8'h44, 1'b1, 1'b1);
    endtask

    task automatic test_register_extremes();
        set_registers(8'h00, 16'h0000);
        send_payload(8'h80, 8'h01, 8'h01, 1'b1, 1'b1);
        set_registers(8'hFF, 16'hFFFF);
        send_payload(8'h7F, 8'h02, 8'hFE, 1'b1, 1'b0);
        send_payload(8'h00, 8'h00, 8'h10, 1'b0, 1'b1);
    endtask

    // receiver held off while the sender keeps offering, then the sender waits it out
    task automatic test_back_pressure();
        int start;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 400;
        hold_seq <= hold_seq + 1;
        start = items_accepted;
        while (items_accepted - start < 30) begin
            send_random_frame();
        end
        drain_frame_bytes();
    endtask

    task automatic test_random_traffic();
        int start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_registers(8'h00, 16'h0000);
                1: set_registers(8'hFF, 16'hFFFF);
                default: set_registers(8'($urandom), 16'($urandom));
            endcase
            // no idling, sender idle, receiver stalling, then both
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            start = items_accepted;
            while (items_accepted - start < 38) begin
                if ($urandom_range(99) < 15) begin
                    // noise: a lone transaction with random flags
                    send_payload(8'($urandom), 8'($urandom), 8'($urandom),
                                 1'($urandom), 1'($urandom));
                end else begin
                    send_random_frame();
                end
            end
            drain_frame_bytes();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_stray_bytes();
        test_single_byte_frames();
        test_multi_byte_frame();
        test_after_frame_end();
        test_seed_mid_frame();
        test_register_extremes();
        test_back_pressure();
        test_random_traffic();

        drain_frame_bytes();
        repeat (8) @(posedge aclk);
        if (expected_bytes.size() != 0) begin
            error_count += expected_bytes.size();
            $display("%0t %0d expected frame bytes never arrived", $time, expected_bytes.size());
        end

        $display("covered %0d payload transactions, %0d frame bytes and %0d closed frames",
                 items_accepted, bytes_checked, frames_closed);
        $display("with %0d register writes, stray and broken frames, stalls and a long hold-off",
                 reg_writes);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // timeout well beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("%0t timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
